### rtl/core/sdle_pkg.sv
// Shared sizes, op and status codes, datapath commands and helpers for the
// sorted delay list engine. No dependencies.
package sdle_pkg;

  localparam int NUM_SLOTS = 32;
  localparam int NUM_LISTS = 8;
  localparam int KEY_BITS  = 32;
  localparam int NUM_NODES = NUM_SLOTS + NUM_LISTS;

  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LIST_W  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int NODE_W  = $clog2(NUM_NODES);
  localparam int COUNT_W = $clog2(NUM_SLOTS + 1);

  // Request field widths as seen on the ports.
  localparam int OP_W      = 3;
  localparam int LIST_ID_W = 3;
  localparam int SLOT_ID_W = 5;
  localparam int STATUS_W  = 2;

  localparam logic [OP_W-1:0] OP_INIT   = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_SORTED = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_LINKED   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNLINKED = 2'd2;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,       // capture the request
    DP_RD_SN,       // read both links of the slot
    DP_RD_CUR,      // a = cursor, read its successor
    DP_RD_TAIL,     // read predecessor of the sentinel
    DP_WALK_START,  // a = sentinel, read its successor
    DP_WALK_STEP,   // a = read successor, read its successor
    DP_GET_B,       // b = read successor
    DP_GET_TAIL,    // a = read predecessor, b = sentinel
    DP_LINK1,       // write the new slot's own links
    DP_LINK2,       // splice neighbors, commit insert, build result
    DP_RM_COMMIT,   // unsplice, commit remove, build result
    DP_RES_LINKED,  // result for a slot already in a list
    DP_RES_ZERO,    // all-zero result
    DP_RES_UNLINK,  // remove of a free slot
    DP_INIT         // clear a list, build result
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            linked;
    logic            key_max;
    logic            walk_stop;
  } stat_t;

  function automatic logic is_sent(input logic [NODE_W-1:0] n);
    return n >= NODE_W'(NUM_SLOTS);
  endfunction

  function automatic logic [NODE_W-1:0] sent_node(input logic [LIST_W-1:0] l);
    return NODE_W'(NUM_SLOTS) + NODE_W'(l);
  endfunction

  function automatic logic [LIST_W-1:0] sent_idx(input logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] d;
    d = n - NODE_W'(NUM_SLOTS);
    return d[LIST_W-1:0];
  endfunction

endpackage

### rtl/core/sdle_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module sdle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/sdle_ctrl.sv
// Request sequencer of the sorted delay list engine: one op at a time.
// Depends on sdle_pkg.
module sdle_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  sdle_pkg::stat_t  stat_i,
  output sdle_pkg::cmd_t   cmd_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DEC    = 4'd1;
  localparam logic [3:0] ST_RES_L  = 4'd2;
  localparam logic [3:0] ST_GET_B  = 4'd3;
  localparam logic [3:0] ST_GET_T  = 4'd4;
  localparam logic [3:0] ST_WALK   = 4'd5;
  localparam logic [3:0] ST_LINK1  = 4'd6;
  localparam logic [3:0] ST_LINK2  = 4'd7;
  localparam logic [3:0] ST_RM     = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d         = state_q;
    cmd_o.op        = sdle_pkg::DP_NOP;
    cmd_o.out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = sdle_pkg::DP_LATCH;
          state_d  = ST_DEC;
        end
      end
      ST_DEC: begin
        state_d = ST_DONE;
        priority if (stat_i.op == sdle_pkg::OP_INIT) begin
          cmd_o.op = sdle_pkg::DP_INIT;
        end else if (stat_i.op == sdle_pkg::OP_FREE) begin
          if (stat_i.linked) begin
            cmd_o.op = sdle_pkg::DP_RD_SN;
            state_d  = ST_RES_L;
          end else begin
            cmd_o.op = sdle_pkg::DP_RES_ZERO;
          end
        end else if (stat_i.op == sdle_pkg::OP_INSERT ||
                     stat_i.op == sdle_pkg::OP_SORTED) begin
          if (stat_i.linked) begin
            cmd_o.op = sdle_pkg::DP_RD_SN;
            state_d  = ST_RES_L;
          end else if (stat_i.op == sdle_pkg::OP_INSERT) begin
            cmd_o.op = sdle_pkg::DP_RD_CUR;
            state_d  = ST_GET_B;
          end else if (stat_i.key_max) begin
            cmd_o.op = sdle_pkg::DP_RD_TAIL;
            state_d  = ST_GET_T;
          end else begin
            cmd_o.op = sdle_pkg::DP_WALK_START;
            state_d  = ST_WALK;
          end
        end else if (stat_i.op == sdle_pkg::OP_REMOVE) begin
          if (stat_i.linked) begin
            cmd_o.op = sdle_pkg::DP_RD_SN;
            state_d  = ST_RM;
          end else begin
            cmd_o.op = sdle_pkg::DP_RES_UNLINK;
          end
        end else begin
          cmd_o.op = sdle_pkg::DP_RES_ZERO;
        end
      end
      ST_RES_L: begin
        cmd_o.op = sdle_pkg::DP_RES_LINKED;
        state_d  = ST_DONE;
      end
      ST_GET_B: begin
        cmd_o.op = sdle_pkg::DP_GET_B;
        state_d  = ST_LINK1;
      end
      ST_GET_T: begin
        cmd_o.op = sdle_pkg::DP_GET_TAIL;
        state_d  = ST_LINK1;
      end
      ST_WALK: begin
        if (stat_i.walk_stop) begin
          cmd_o.op = sdle_pkg::DP_GET_B;
          state_d  = ST_LINK1;
        end else begin
          cmd_o.op = sdle_pkg::DP_WALK_STEP;
        end
      end
      ST_LINK1: begin
        cmd_o.op = sdle_pkg::DP_LINK1;
        state_d  = ST_LINK2;
      end
      ST_LINK2: begin
        cmd_o.op = sdle_pkg::DP_LINK2;
        state_d  = ST_DONE;
      end
      ST_RM: begin
        cmd_o.op = sdle_pkg::DP_RM_COMMIT;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

  // an accepted request is decoded in the next cycle
  a_accept_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_DEC))
    else $error("accepted request not decoded");

  // each request loads exactly one result before the next is taken
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (state_q == ST_IDLE))
    else $error("result load outside request end");

endmodule

### rtl/core/sdle_dp.sv
// Datapath of the sorted delay list engine: link RAMs, slot and list state,
// walk compare and result registers. Depends on sdle_pkg and sdle_ram.
module sdle_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [sdle_pkg::OP_W-1:0]           op_i,
  input  logic [sdle_pkg::LIST_ID_W-1:0]      list_id_i,
  input  logic [sdle_pkg::SLOT_ID_W-1:0]      slot_i,
  input  logic [sdle_pkg::KEY_BITS-1:0]       key_i,
  input  sdle_pkg::cmd_t                      cmd_i,
  output sdle_pkg::stat_t                     stat_o,
  output logic [sdle_pkg::STATUS_W-1:0]       status_o,
  output logic [sdle_pkg::COUNT_W-1:0]        list_count_o,
  output logic [sdle_pkg::NODE_W-1:0]         prev_link_o,
  output logic [sdle_pkg::NODE_W-1:0]         next_link_o,
  output logic [sdle_pkg::NODE_W-1:0]         cursor_pos_o
);

  localparam int NW = sdle_pkg::NODE_W;
  localparam int LW = sdle_pkg::LIST_W;
  localparam int SW = sdle_pkg::SLOT_W;
  localparam int CW = sdle_pkg::COUNT_W;
  localparam int KW = sdle_pkg::KEY_BITS;
  localparam int NS = sdle_pkg::NUM_SLOTS;
  localparam int NL = sdle_pkg::NUM_LISTS;

  // request
  logic [sdle_pkg::OP_W-1:0] op_q;
  logic [LW-1:0]             l_q;
  logic [SW-1:0]             s_q;
  logic [KW-1:0]             key_q;
  logic [NW-1:0]             a_q, b_q;

  // slot and list state
  logic          linked_q [NS];
  logic [LW-1:0] owner_q  [NS];
  logic [KW-1:0] skey_q   [NS];
  logic [NW-1:0] cursor_q [NL];
  logic [CW-1:0] size_q   [NL];
  // sentinel entries of the link RAMs read as self-pointing until written
  logic [NL-1:0] nv_q, pv_q;

  // link RAM ports
  logic          nxt_we, prv_we;
  logic [NW-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd;
  logic [NW-1:0] nxt_ra, prv_ra, nxt_ra_q, prv_ra_q;
  logic [NW-1:0] nxt_rd, prv_rd, nxt_eff, prv_eff;

  // result
  logic                          res_we;
  logic [sdle_pkg::STATUS_W-1:0] res_st_d, res_st_q;
  logic [CW-1:0]                 res_cnt_d, res_cnt_q;
  logic [NW-1:0]                 res_pl_d, res_pl_q, res_nl_d, res_nl_q, res_cur_d, res_cur_q;

  logic [NW-1:0] sent;
  logic [LW-1:0] aff;
  logic [KW-1:0] key_b;

  sdle_ram #(.WIDTH(NW), .DEPTH(sdle_pkg::NUM_NODES)) u_nxt_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_wa),
    .wdata_i (nxt_wd),
    .raddr_i (nxt_ra),
    .rdata_o (nxt_rd)
  );

  sdle_ram #(.WIDTH(NW), .DEPTH(sdle_pkg::NUM_NODES)) u_prv_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_wa),
    .wdata_i (prv_wd),
    .raddr_i (prv_ra),
    .rdata_o (prv_rd)
  );

  assign sent = sdle_pkg::sent_node(l_q);
  assign aff  = (op_q == sdle_pkg::OP_FREE || op_q == sdle_pkg::OP_REMOVE) ?
                owner_q[s_q] : l_q;

  assign nxt_eff = (sdle_pkg::is_sent(nxt_ra_q) && !nv_q[sdle_pkg::sent_idx(nxt_ra_q)]) ?
                   nxt_ra_q : nxt_rd;
  assign prv_eff = (sdle_pkg::is_sent(prv_ra_q) && !pv_q[sdle_pkg::sent_idx(prv_ra_q)]) ?
                   prv_ra_q : prv_rd;

  assign key_b = skey_q[nxt_eff[SW-1:0]];

  assign stat_o.op        = op_q;
  assign stat_o.linked    = linked_q[s_q];
  assign stat_o.key_max   = (key_q == {KW{1'b1}});
  assign stat_o.walk_stop = sdle_pkg::is_sent(nxt_eff) || (key_b > key_q);

  always_comb begin
    nxt_we    = 1'b0;
    prv_we    = 1'b0;
    nxt_wa    = a_q;
    nxt_wd    = b_q;
    prv_wa    = b_q;
    prv_wd    = a_q;
    nxt_ra    = nxt_ra_q;
    prv_ra    = prv_ra_q;
    res_we    = 1'b0;
    res_st_d  = sdle_pkg::STATUS_OK;
    res_cnt_d = '0;
    res_pl_d  = '0;
    res_nl_d  = '0;
    res_cur_d = '0;
    unique case (cmd_i.op)
      sdle_pkg::DP_RD_SN: begin
        nxt_ra = NW'(s_q);
        prv_ra = NW'(s_q);
      end
      sdle_pkg::DP_RD_CUR:     nxt_ra = cursor_q[l_q];
      sdle_pkg::DP_RD_TAIL:    prv_ra = sent;
      sdle_pkg::DP_WALK_START: nxt_ra = sent;
      sdle_pkg::DP_WALK_STEP:  nxt_ra = nxt_eff;
      sdle_pkg::DP_LINK1: begin
        nxt_we = 1'b1;
        nxt_wa = NW'(s_q);
        nxt_wd = b_q;
        prv_we = 1'b1;
        prv_wa = NW'(s_q);
        prv_wd = a_q;
      end
      sdle_pkg::DP_LINK2: begin
        nxt_we    = 1'b1;
        nxt_wa    = a_q;
        nxt_wd    = NW'(s_q);
        prv_we    = 1'b1;
        prv_wa    = b_q;
        prv_wd    = NW'(s_q);
        res_we    = 1'b1;
        res_cnt_d = size_q[l_q] + CW'(1);
        res_pl_d  = a_q;
        res_nl_d  = b_q;
        res_cur_d = (op_q == sdle_pkg::OP_INSERT) ? NW'(s_q) : cursor_q[l_q];
      end
      sdle_pkg::DP_RM_COMMIT: begin
        nxt_we    = 1'b1;
        nxt_wa    = prv_eff;
        nxt_wd    = nxt_eff;
        prv_we    = 1'b1;
        prv_wa    = nxt_eff;
        prv_wd    = prv_eff;
        res_we    = 1'b1;
        res_cnt_d = (size_q[aff] != '0) ? size_q[aff] - CW'(1) : '0;
        res_pl_d  = prv_eff;
        res_nl_d  = nxt_eff;
        res_cur_d = (cursor_q[aff] == NW'(s_q)) ? prv_eff : cursor_q[aff];
      end
      sdle_pkg::DP_RES_LINKED: begin
        res_we    = 1'b1;
        res_st_d  = sdle_pkg::STATUS_LINKED;
        res_cnt_d = size_q[aff];
        res_pl_d  = prv_eff;
        res_nl_d  = nxt_eff;
        res_cur_d = cursor_q[aff];
      end
      sdle_pkg::DP_RES_ZERO:   res_we = 1'b1;
      sdle_pkg::DP_RES_UNLINK: begin
        res_we   = 1'b1;
        res_st_d = sdle_pkg::STATUS_UNLINKED;
      end
      sdle_pkg::DP_INIT: begin
        res_we    = 1'b1;
        res_pl_d  = sent;
        res_nl_d  = sent;
        res_cur_d = sent;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= '0;
      pv_q <= '0;
      for (int i = 0; i < NS; i++) linked_q[i] <= 1'b0;
      for (int j = 0; j < NL; j++) begin
        cursor_q[j] <= sdle_pkg::sent_node(LW'(j));
        size_q[j]   <= '0;
      end
    end else begin
      if (nxt_we && sdle_pkg::is_sent(nxt_wa)) nv_q[sdle_pkg::sent_idx(nxt_wa)] <= 1'b1;
      if (prv_we && sdle_pkg::is_sent(prv_wa)) pv_q[sdle_pkg::sent_idx(prv_wa)] <= 1'b1;
      unique case (cmd_i.op)
        sdle_pkg::DP_LINK2: begin
          linked_q[s_q] <= 1'b1;
          size_q[l_q]   <= res_cnt_d;
          cursor_q[l_q] <= res_cur_d;
        end
        sdle_pkg::DP_RM_COMMIT: begin
          linked_q[s_q] <= 1'b0;
          size_q[aff]   <= res_cnt_d;
          cursor_q[aff] <= res_cur_d;
        end
        sdle_pkg::DP_INIT: begin
          nv_q[l_q]     <= 1'b0;
          pv_q[l_q]     <= 1'b0;
          cursor_q[l_q] <= sent;
          size_q[l_q]   <= '0;
          for (int i = 0; i < NS; i++) begin
            if (linked_q[i] && owner_q[i] == l_q) linked_q[i] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    nxt_ra_q <= nxt_ra;
    prv_ra_q <= prv_ra;
    if (cmd_i.op == sdle_pkg::DP_LATCH) begin
      op_q  <= op_i;
      l_q   <= list_id_i[LW-1:0];
      s_q   <= slot_i[SW-1:0];
      key_q <= key_i[KW-1:0];
    end
    unique case (cmd_i.op)
      sdle_pkg::DP_RD_CUR:     a_q <= cursor_q[l_q];
      sdle_pkg::DP_WALK_START: a_q <= sent;
      sdle_pkg::DP_WALK_STEP:  a_q <= nxt_eff;
      sdle_pkg::DP_GET_B:      b_q <= nxt_eff;
      sdle_pkg::DP_GET_TAIL: begin
        a_q <= prv_eff;
        b_q <= sent;
      end
      sdle_pkg::DP_LINK2: begin
        skey_q[s_q]  <= key_q;
        owner_q[s_q] <= l_q;
      end
      default: ;
    endcase
    if (res_we) begin
      res_st_q  <= res_st_d;
      res_cnt_q <= res_cnt_d;
      res_pl_q  <= res_pl_d;
      res_nl_q  <= res_nl_d;
      res_cur_q <= res_cur_d;
    end
    if (cmd_i.out_load) begin
      status_o     <= res_st_q;
      list_count_o <= res_cnt_q;
      prev_link_o  <= res_pl_q;
      next_link_o  <= res_nl_q;
      cursor_pos_o <= res_cur_q;
    end
  end

  // the walk only advances over slots, never past a sentinel
  a_walk_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == sdle_pkg::DP_WALK_STEP) |-> !sdle_pkg::is_sent(nxt_eff))
    else $error("walk stepped onto a sentinel");

  // an insert commit leaves the slot linked
  a_ins_linked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == sdle_pkg::DP_LINK2) |=> linked_q[s_q])
    else $error("inserted slot not linked");

endmodule

### rtl/core/sorted_delay_list_engine.sv
// Top level of the sorted delay list engine: request sequencer plus datapath.
// Depends on sdle_pkg, sdle_ctrl, sdle_dp (and sdle_ram through sdle_dp).

// Keeps eight sorted doubly linked lists over 32 item slots, each closed by a
// sentinel node (32 plus list id) that counts as the maximum key. One request
// is handled at a time and gives exactly one result. After the decode state,
// init, free of a free slot, remove of a free slot and undefined ops go
// straight to the done state; free or insert of a linked slot reads the
// slot's links and then builds the result, and remove of a linked slot reads
// them and then commits the unsplice; insert at cursor and a maximum-key
// sorted insert read a neighbor, then write the slot's links and splice it
// in. A sorted insert walks the list one entry per cycle through the
// next-link RAM read port before it links. The sequencer returns to idle
// before it takes the next request. The request channel stalls while a
// request is in work; a finished result sits in the output register, so the
// next request is taken while it waits, but that next request holds in its
// last step until the output is free.
module sorted_delay_list_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [sdle_pkg::OP_W-1:0]           op_i,
  input  logic [sdle_pkg::LIST_ID_W-1:0]      list_id_i,
  input  logic [sdle_pkg::SLOT_ID_W-1:0]      slot_i,
  input  logic [sdle_pkg::KEY_BITS-1:0]       key_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [sdle_pkg::STATUS_W-1:0]       status_o,
  output logic [sdle_pkg::COUNT_W-1:0]        list_count_o,
  output logic [sdle_pkg::NODE_W-1:0]         prev_link_o,
  output logic [sdle_pkg::NODE_W-1:0]         next_link_o,
  output logic [sdle_pkg::NODE_W-1:0]         cursor_pos_o
);

  sdle_pkg::cmd_t  cmd;
  sdle_pkg::stat_t stat;

  // sequencer: one state per link RAM access or commit step
  sdle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: link RAMs, slot keys, ownership, cursors, counts, result regs
  sdle_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op_i),
    .list_id_i    (list_id_i),
    .slot_i       (slot_i),
    .key_i        (key_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .status_o     (status_o),
    .list_count_o (list_count_o),
    .prev_link_o  (prev_link_o),
    .next_link_o  (next_link_o),
    .cursor_pos_o (cursor_pos_o)
  );

endmodule
